/* design/qvr_pkg.sv */
// Shared types and constants for the quaternion rotation pipeline.
package qvr_pkg;

	// Widths of the input, the first product and the second product.
	localparam int VW = 16;
	localparam int M1W = 32;
	localparam int PW = 34;
	localparam int M2W = 50;
	localparam int RW = 52;

	// Fraction bits removed at the end (two Q1.14 scalings).
	localparam int FRAC_SHIFT = 28;
	localparam int SHW = RW - FRAC_SHIFT;

	// Saturation limits of an output component.
	localparam logic signed [VW-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [VW-1:0] OUT_MIN = 16'sh8000;

	// Rounding bias, one half of the output LSB.
	localparam logic signed [RW-1:0] RND_BIAS = RW'(64'sd1 << (FRAC_SHIFT - 1));

	// A quaternion with 16-bit components.
	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
		logic signed [VW-1:0] w;
	} quat16_t;

	// The exact first product q * v.
	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic signed [PW-1:0] z;
		logic signed [PW-1:0] w;
	} quat34_t;

	// The exact second product with the rounding bias added.
	typedef struct packed {
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [RW-1:0] z;
		logic signed [RW-1:0] w;
	} quat52_t;

endpackage

/* design/qvr_qmul.sv */
// First Hamilton product p = q * v: a multiply stage and a sum stage.
module qvr_qmul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qvr_pkg::quat16_t rot,
	input  qvr_pkg::quat16_t vec,
	output logic             out_valid,
	input  logic             out_ready,
	output qvr_pkg::quat34_t prod,
	output qvr_pkg::quat16_t rot_out
);
	import qvr_pkg::*;

	logic                  v_s1, v_s2;
	logic                  en1, en2;
	logic signed [M1W-1:0] m_s1 [16];
	quat16_t               rot_s1, rot_s2;
	quat34_t               p_s2;

	// A stage loads when it is empty or its word moves on.
	assign en2 = !v_s2 || out_ready;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: the sixteen 16 x 16 partial products.
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			m_s1[0]  <= rot.x * vec.w;
			m_s1[1]  <= rot.w * vec.x;
			m_s1[2]  <= rot.y * vec.z;
			m_s1[3]  <= rot.z * vec.y;
			m_s1[4]  <= rot.y * vec.w;
			m_s1[5]  <= rot.w * vec.y;
			m_s1[6]  <= rot.z * vec.x;
			m_s1[7]  <= rot.x * vec.z;
			m_s1[8]  <= rot.z * vec.w;
			m_s1[9]  <= rot.w * vec.z;
			m_s1[10] <= rot.x * vec.y;
			m_s1[11] <= rot.y * vec.x;
			m_s1[12] <= rot.w * vec.w;
			m_s1[13] <= rot.x * vec.x;
			m_s1[14] <= rot.y * vec.y;
			m_s1[15] <= rot.z * vec.z;
			rot_s1   <= rot;
		end
	end

	// Stage 2: sum the partial products into the four components of p.
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			p_s2.x <= PW'(m_s1[0]) + PW'(m_s1[1]) + PW'(m_s1[2]) - PW'(m_s1[3]);
			p_s2.y <= PW'(m_s1[4]) + PW'(m_s1[5]) + PW'(m_s1[6]) - PW'(m_s1[7]);
			p_s2.z <= PW'(m_s1[8]) + PW'(m_s1[9]) + PW'(m_s1[10]) - PW'(m_s1[11]);
			p_s2.w <= PW'(m_s1[12]) - PW'(m_s1[13]) - PW'(m_s1[14]) - PW'(m_s1[15]);
			rot_s2 <= rot_s1;
		end
	end

	assign out_valid = v_s2;
	assign prod = p_s2;
	assign rot_out = rot_s2;

endmodule

/* design/qvr_cmul.sv */
// Second Hamilton product p * conj(q): a multiply stage and a sum stage.
module qvr_cmul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qvr_pkg::quat34_t prod,
	input  qvr_pkg::quat16_t rot,
	output logic             out_valid,
	input  logic             out_ready,
	output qvr_pkg::quat52_t sum
);
	import qvr_pkg::*;

	logic                  v_s3, v_s4;
	logic                  en3, en4;
	logic signed [M2W-1:0] m_s3 [16];
	quat52_t               r_s4;

	// A stage loads when it is empty or its word moves on.
	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign in_ready = en3;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= in_valid;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 3: the sixteen 34 x 16 partial products; the conjugate's
	// negated vector part is folded into the signs of the sums below.
	always_ff @(posedge clk) begin
		if (en3 && in_valid) begin
			m_s3[0]  <= prod.x * rot.w;
			m_s3[1]  <= prod.w * rot.x;
			m_s3[2]  <= prod.y * rot.z;
			m_s3[3]  <= prod.z * rot.y;
			m_s3[4]  <= prod.y * rot.w;
			m_s3[5]  <= prod.w * rot.y;
			m_s3[6]  <= prod.z * rot.x;
			m_s3[7]  <= prod.x * rot.z;
			m_s3[8]  <= prod.z * rot.w;
			m_s3[9]  <= prod.w * rot.z;
			m_s3[10] <= prod.x * rot.y;
			m_s3[11] <= prod.y * rot.x;
			m_s3[12] <= prod.w * rot.w;
			m_s3[13] <= prod.x * rot.x;
			m_s3[14] <= prod.y * rot.y;
			m_s3[15] <= prod.z * rot.z;
		end
	end

	// Stage 4: sum the partial products and add the rounding bias.
	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			r_s4.x <= RW'(m_s3[0]) - RW'(m_s3[1]) - RW'(m_s3[2]) + RW'(m_s3[3])
				+ RND_BIAS;
			r_s4.y <= RW'(m_s3[4]) - RW'(m_s3[5]) - RW'(m_s3[6]) + RW'(m_s3[7])
				+ RND_BIAS;
			r_s4.z <= RW'(m_s3[8]) - RW'(m_s3[9]) - RW'(m_s3[10]) + RW'(m_s3[11])
				+ RND_BIAS;
			r_s4.w <= RW'(m_s3[12]) + RW'(m_s3[13]) + RW'(m_s3[14]) + RW'(m_s3[15])
				+ RND_BIAS;
		end
	end

	assign out_valid = v_s4;
	assign sum = r_s4;

endmodule

/* design/qvr_sat.sv */
// Output stage: drop the fraction bits, saturate to 16 bits and hold the word.
module qvr_sat (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qvr_pkg::quat52_t sum,
	output logic             out_valid,
	input  logic             out_stall,
	output qvr_pkg::quat16_t res,
	output logic             sat
);
	import qvr_pkg::*;

	logic                  v_s5;
	logic                  en5;
	logic signed [SHW-1:0] sh [4];
	logic                  clip [4];
	logic signed [VW-1:0]  lim [4];
	quat16_t               res_s5;
	logic                  sat_s5;

	assign en5 = !v_s5 || !out_stall;
	assign in_ready = en5;

	// Floor shift of the biased sums; a component clips when its upper
	// bits are not all copies of the sign.
	always_comb begin
		sh[0] = sum.x[RW-1:FRAC_SHIFT];
		sh[1] = sum.y[RW-1:FRAC_SHIFT];
		sh[2] = sum.z[RW-1:FRAC_SHIFT];
		sh[3] = sum.w[RW-1:FRAC_SHIFT];
		for (int i = 0; i < 4; i++) begin
			clip[i] = (sh[i][SHW-1:VW-1] != {(SHW-VW+1){sh[i][SHW-1]}});
			if (clip[i]) begin
				lim[i] = sh[i][SHW-1] ? OUT_MIN : OUT_MAX;
			end else begin
				lim[i] = sh[i][VW-1:0];
			end
		end
	end

	// Valid bit of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= in_valid;
		end
	end

	// Stage 5: the output register.
	always_ff @(posedge clk) begin
		if (en5 && in_valid) begin
			res_s5.x <= lim[0];
			res_s5.y <= lim[1];
			res_s5.z <= lim[2];
			res_s5.w <= lim[3];
			sat_s5   <= clip[0] | clip[1] | clip[2] | clip[3];
		end
	end

	assign out_valid = v_s5;
	assign res = res_s5;
	assign sat = sat_s5;

endmodule

/* design/quaternion_vector_rotate.sv */
// Quaternion rotation r = q * v * conj(q), top level of the pipeline.
// The block takes one word per clock when the output is not stalled, and
// works in stages in this order: stage 1 forms the 16 x 16 products
// of q * v, stage 2 sums them exactly, stage 3 forms the 34 x 16 products
// with conj(q), stage 4 sums them with a half-LSB rounding bias, and
// stage 5 drops 28 fraction bits and saturates into the output register.
// Each stage loads whenever it is empty or its word moves on, so bubbles
// close up and a stall at the output backs up without losing a word. The
// rotation quaternion is not normalized; results that do not fit in 16 bits
// are clamped and flagged on saturated.
module quaternion_vector_rotate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] vec_x,
	input  logic signed [15:0] vec_y,
	input  logic signed [15:0] vec_z,
	input  logic signed [15:0] vec_w,
	input  logic signed [15:0] rot_x,
	input  logic signed [15:0] rot_y,
	input  logic signed [15:0] rot_z,
	input  logic signed [15:0] rot_w,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic signed [15:0] out_w,
	output logic               saturated
);
	import qvr_pkg::*;

	quat16_t vec, rot, rot_p, res;
	quat34_t prod;
	quat52_t sum;
	logic    q_ready, p_valid, c_ready, c_valid, s_ready;

	// Gather the input word.
	assign vec = '{x: vec_x, y: vec_y, z: vec_z, w: vec_w};
	assign rot = '{x: rot_x, y: rot_y, z: rot_z, w: rot_w};

	// First product.
	qvr_qmul u_qmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (q_ready),
		.rot       (rot),
		.vec       (vec),
		.out_valid (p_valid),
		.out_ready (c_ready),
		.prod      (prod),
		.rot_out   (rot_p)
	);

	// Second product with the conjugate.
	qvr_cmul u_cmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (c_ready),
		.prod      (prod),
		.rot       (rot_p),
		.out_valid (c_valid),
		.out_ready (s_ready),
		.sum       (sum)
	);

	// Rounding, saturation and output register.
	qvr_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_ready  (s_ready),
		.sum       (sum),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.sat       (saturated)
	);

	assign in_stall = !q_ready;
	assign out_x = res.x;
	assign out_y = res.y;
	assign out_z = res.z;
	assign out_w = res.w;

endmodule

/* design/qvr_checker.sv */
// Port-level assertions for the quaternion rotation block and their bind.
module qvr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_z,
	input logic signed [15:0] out_w,
	input logic               saturated
);

	// The input backs up only when the output holds a stalled word.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output register can move");

	// A stalled output word stays and keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(out_w) && $stable(saturated)))
		else $error("stalled output word changed");

	// A flagged word has at least one component at a limit.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (out_x == 16'sh7fff || out_x == 16'sh8000
			|| out_y == 16'sh7fff || out_y == 16'sh8000
			|| out_z == 16'sh7fff || out_z == 16'sh8000
			|| out_w == 16'sh7fff || out_w == 16'sh8000))
		else $error("saturation flag without a clamped component");

	// With the output empty, new words are always taken.
	a_empty_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !out_valid) |-> !in_stall)
		else $error("input stalled with an empty output register");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z),
	.out_w     (out_w),
	.saturated (saturated)
);

/* verif/quaternion_vector_rotate_tb.sv */
// Testbench for quaternion_vector_rotate: random and directed rotations checked against a predictor.
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;
	import qvr_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS = 100;
	localparam int REPORT_LIMIT = 10;

	// One rotated word as the block should return it.
	typedef struct {
		quat16_t r;
		logic    sat;
	} rotated_word_t;

	// Keeps the rotations still owed by the block and checks each returned word.
	class rotation_scoreboard;
		rotated_word_t rotations_due[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Round, shift and clamp one component to 16 bits and flag it if it did not fit.
		function logic signed [15:0] clamp_component(longint acc, inout logic sat);
			longint shifted;
			shifted = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
			if (shifted > longint'(OUT_MAX)) begin
				sat = 1'b1;
				return OUT_MAX;
			end
			if (shifted < longint'(OUT_MIN)) begin
				sat = 1'b1;
				return OUT_MIN;
			end
			return shifted[15:0];
		endfunction

		// r = q * v * conj(q), both products exact, then round, shift and clamp.
		function rotated_word_t rotate(quat16_t v, quat16_t q);
			longint vx, vy, vz, vw, qx, qy, qz, qw;
			longint px, py, pz, pw;
			rotated_word_t res;
			vx = $signed(v.x);
			vy = $signed(v.y);
			vz = $signed(v.z);
			vw = $signed(v.w);
			qx = $signed(q.x);
			qy = $signed(q.y);
			qz = $signed(q.z);
			qw = $signed(q.w);
			px = qx * vw + qw * vx + qy * vz - qz * vy;
			py = qy * vw + qw * vy + qz * vx - qx * vz;
			pz = qz * vw + qw * vz + qx * vy - qy * vx;
			pw = qw * vw - qx * vx - qy * vy - qz * vz;
			res.sat = 1'b0;
			res.r.x = clamp_component(px * qw - pw * qx - py * qz + pz * qy, res.sat);
			res.r.y = clamp_component(py * qw - pw * qy - pz * qx + px * qz, res.sat);
			res.r.z = clamp_component(pz * qw - pw * qz - px * qy + py * qx, res.sat);
			res.r.w = clamp_component(pw * qw + px * qx + py * qy + pz * qz, res.sat);
			return res;
		endfunction

		function void note_input(quat16_t v, quat16_t q);
			rotations_due.push_back(rotate(v, q));
		endfunction

		function int pending();
			return rotations_due.size();
		endfunction

		// Compare a returned word with the oldest rotation still owed.
		function void check_result(quat16_t r, logic sat);
			rotated_word_t exp_word;
			if (rotations_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("Unexpected word: x=%0d y=%0d z=%0d w=%0d sat=%0b",
						r.x, r.y, r.z, r.w, sat);
				return;
			end
			exp_word = rotations_due.pop_front();
			if (r.x !== exp_word.r.x || r.y !== exp_word.r.y || r.z !== exp_word.r.z ||
				r.w !== exp_word.r.w || sat !== exp_word.sat) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$write("Mismatch: expected x=%0d y=%0d z=%0d w=%0d sat=%0b, ",
						exp_word.r.x, exp_word.r.y, exp_word.r.z, exp_word.r.w,
						exp_word.sat);
					$display("got x=%0d y=%0d z=%0d w=%0d sat=%0b",
						r.x, r.y, r.z, r.w, sat);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] vec_x, vec_y, vec_z, vec_w;
	logic signed [15:0] rot_x, rot_y, rot_z, rot_w;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] out_x, out_y, out_z, out_w;
	logic saturated;

	rotation_scoreboard sb;
	int idle_pct;
	int stall_pct;
	logic hold_request;
	int quiet_cycles;

	quaternion_vector_rotate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.vec_w     (vec_w),
		.rot_x     (rot_x),
		.rot_y     (rot_y),
		.rot_z     (rot_z),
		.rot_w     (rot_w),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.saturated (saturated)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Signed value in [lo, hi], truncated to 16 bits.
	function automatic logic signed [15:0] pick(int lo, int hi);
		return 16'(lo + int'($urandom_range(hi - lo)));
	endfunction

	// Offer one word, with random idle cycles first, and wait until it is taken.
	task automatic send_word(input quat16_t v, input quat16_t q);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		vec_x <= v.x;
		vec_y <= v.y;
		vec_z <= v.z;
		vec_w <= v.w;
		rot_x <= q.x;
		rot_y <= q.y;
		rot_z <= q.z;
		rot_w <= q.w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(v, q);
	endtask

	task automatic send_parts(input int vx, input int vy, input int vz, input int vw,
		input int qx, input int qy, input int qz, input int qw);
		quat16_t v, q;
		v.x = 16'(vx);
		v.y = 16'(vy);
		v.z = 16'(vz);
		v.w = 16'(vw);
		q.x = 16'(qx);
		q.y = 16'(qy);
		q.z = 16'(qz);
		q.w = 16'(qw);
		send_word(v, q);
	endtask

	// Random word drawn from one of several shapes of rotation.
	task automatic make_random(output quat16_t v, output quat16_t q);
		int shape;
		shape = $urandom_range(3);
		v.x = pick(-32768, 32767);
		v.y = pick(-32768, 32767);
		v.z = pick(-32768, 32767);
		v.w = pick(-32768, 32767);
		q.x = pick(-16384, 16384);
		q.y = pick(-16384, 16384);
		q.z = pick(-16384, 16384);
		q.w = pick(-16384, 16384);
		case (shape)
			1: begin
				// Pure vector under a rotation of at most unit norm.
				v.w = '0;
				q.x = pick(-8192, 8192);
				q.y = pick(-8192, 8192);
				q.z = pick(-8192, 8192);
				q.w = pick(-8192, 8192);
			end
			2: begin
				// Small vector, so most results stay in range.
				v.x = pick(-4096, 4096);
				v.y = pick(-4096, 4096);
				v.z = pick(-4096, 4096);
				v.w = pick(-4096, 4096);
			end
			3: begin
				// Rotation about a single axis.
				case ($urandom_range(2))
					0: begin q.y = '0; q.z = '0; end
					1: begin q.x = '0; q.z = '0; end
					default: begin q.x = '0; q.y = '0; end
				endcase
			end
			default: ;
		endcase
	endtask

	// Edge cases: identity, half-turns, exact halves, non-unit and out-of-range rotations.
	task automatic run_directed();
		send_parts(0, 0, 0, 0, 0, 0, 0, 0);
		send_parts(32767, -32768, 1, -1, 0, 0, 0, 16384);
		send_parts(-32768, 32767, -1, 0, 0, 0, 0, 16384);
		send_parts(12345, -23456, 7, 0, 0, 0, 0, -16384);
		send_parts(1000, 2000, 3000, 4000, 16384, 0, 0, 0);
		send_parts(1000, 2000, 3000, 4000, 0, 16384, 0, 0);
		send_parts(-32768, -32768, -32768, -32768, 0, 0, 16384, 0);
		send_parts(10000, 0, 0, 0, 0, 0, 11585, 11585);
		send_parts(32767, 32767, 32767, 32767, -16384, -16384, -16384, -16384);
		send_parts(-32768, -32768, -32768, -32768, 16384, 16384, 16384, 16384);
		send_parts(2, -2, 6, -6, 0, 0, 0, 8192);
		send_parts(1, -1, 3, -3, 0, 0, 0, 8192);
		send_parts(1, 1, 1, 1, -32768, 0, 0, 0);
		send_parts(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
		send_parts(0, 0, 0, 32767, 8192, 8192, 8192, 8192);
		send_parts(100, -200, 300, 0, 8192, 8192, 8192, 8192);
		send_parts(-1, -1, -1, -1, 16384, -16384, 0, 0);
	endtask

	// Receiver: random stalls, plus one long hold-off while the sender keeps going.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Every word the block hands over is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			quat16_t r;
			r.x = out_x;
			r.y = out_y;
			r.z = out_z;
			r.w = out_w;
			sb.check_result(r, saturated);
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		quat16_t v, q;
		sb = new();
		quiet_cycles = 0;
		hold_request = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		vec_w = '0;
		rot_x = '0;
		rot_y = '0;
		rot_z = '0;
		rot_w = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Random phases with sender idling and receiver stalls, the last one with the long receiver hold-off.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin idle_pct = 71; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 71; end
				3: begin idle_pct = 25; stall_pct = 25; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			if (ph == 4)
				hold_request = 1'b1;
			repeat (PHASE_WORDS) begin
				make_random(v, q);
				send_word(v, q);
			end
		end
		in_valid <= 1'b0;

		// Drain, then leave time for any stray word to show up.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
design/qvr_pkg.sv
design/qvr_qmul.sv
design/qvr_cmul.sv
design/qvr_sat.sv
design/quaternion_vector_rotate.sv
design/qvr_checker.sv
verif/quaternion_vector_rotate_tb.sv
